/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL files.
// Each macro reports through $error only.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication that holds while out of reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Plain condition that holds while out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

`endif

/* rtl/stmf_pkg.sv */
// Package for the sliding trimmed mean filter.
// Types, constants and controller/datapath command and status structs.
package stmf_pkg;

  localparam int unsigned MaxWindow   = 127;
  localparam int unsigned SampleWidth = 16;
  localparam int unsigned CfgWidth    = 7;
  localparam logic [CfgWidth-1:0] WindowReset = 7'd5;

  typedef enum logic [7:0] {
    StIdle   = 8'b0000_0001,
    StExpire = 8'b0000_0010,
    StLowPop = 8'b0000_0100,
    StHiPop  = 8'b0000_1000,
    StPush   = 8'b0001_0000,
    StDivSet = 8'b0010_0000,
    StDiv    = 8'b0100_0000,
    StOut    = 8'b1000_0000
  } stmf_state_e;

  typedef struct packed {
    logic take;       // latch sample, advance tag, drop oldest if full
    logic expire;     // check queue heads against tag
    logic low_pop;    // compare/pop low tail
    logic hi_pop;     // compare/pop high tail
    logic push;       // write both queues and ring
    logic div_start;  // load divider
    logic div_step;   // one quotient bit
    logic clear;      // config write
  } stmf_cmd_t;

  typedef struct packed {
    logic low_pop_more;
    logic hi_pop_more;
    logic div_done;
  } stmf_sts_t;

endpackage

/* rtl/stmf_ctrl.sv */
// Controller state machine of the trimmed mean filter.
// Depends on stmf_pkg; drives stmf_datapath through command structs.
`include "assert_macros.svh"
module stmf_ctrl
  import stmf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  logic      cfg_we_i,
  input  stmf_sts_t sts_i,
  output stmf_cmd_t cmd_o
);

  stmf_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.clear = cfg_we_i;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = StExpire;
        end
      end
      StExpire: begin
        cmd_o.expire = 1'b1;
        state_d      = StLowPop;
      end
      StLowPop: begin
        cmd_o.low_pop = 1'b1;
        if (!sts_i.low_pop_more) state_d = StHiPop;
      end
      StHiPop: begin
        cmd_o.hi_pop = 1'b1;
        if (!sts_i.hi_pop_more) state_d = StPush;
      end
      StPush: begin
        cmd_o.push = 1'b1;
        state_d    = StDivSet;
      end
      StDivSet: begin
        cmd_o.div_start = 1'b1;
        state_d         = StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) state_d = StOut;
      end
      StOut: begin
        out_valid_o = 1'b1;
        in_ready_o  = out_ready_i;
        if (out_ready_i) begin
          if (in_valid_i) begin
            cmd_o.take = 1'b1;
            state_d    = StExpire;
          end else begin
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  `ASSERT_ALWAYS(a_onehot, clk_i, rst_ni, $onehot(state_q))
  `ASSERT_IMPL(a_out_only, clk_i, rst_ni, out_valid_o, state_q == StOut)
  `ASSERT_IMPL(a_push_next, clk_i, rst_ni, cmd_o.push, ##1 cmd_o.div_start)
endmodule

/* rtl/stmf_datapath.sv */
// Datapath of the trimmed mean filter: ring, sum, min/max queues, divider.
// Depends on stmf_pkg; sequenced by stmf_ctrl.
`include "assert_macros.svh"
module stmf_datapath
  import stmf_pkg::*;
#(
  parameter int unsigned MAX_WINDOW   = MaxWindow,
  parameter int unsigned SAMPLE_WIDTH = SampleWidth
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [CfgWidth-1:0]            cfg_wdata_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  stmf_cmd_t                      cmd_i,
  output stmf_sts_t                      sts_o,
  output logic signed [SAMPLE_WIDTH-1:0] filtered_o,
  output logic [CfgWidth-1:0]            held_count_o
);

  localparam int unsigned IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned CW = $clog2(MAX_WINDOW + 1);
  localparam int unsigned TW = CW + 1;
  localparam int unsigned SW = SAMPLE_WIDTH + CW + 1;
  localparam int unsigned QW = SW;
  localparam logic [CW-1:0] MaxW = CW'(MAX_WINDOW);

  logic [CfgWidth-1:0] win_cfg_q;
  logic [CW-1:0] w;
  always_comb begin
    if (win_cfg_q == '0) w = CW'(1);
    else if (CW'(win_cfg_q) > MaxW || 32'(win_cfg_q) > MAX_WINDOW) w = MaxW;
    else w = CW'(win_cfg_q);
  end

  function automatic logic [IW-1:0] inc_ptr(input logic [IW-1:0] p);
    inc_ptr = (32'(p) == MAX_WINDOW - 1) ? '0 : p + IW'(1);
  endfunction
  function automatic logic [IW-1:0] add_ptr(input logic [IW-1:0] p, input logic [CW-1:0] n);
    logic [CW:0] s;
    s = (CW+1)'(p) + (CW+1)'(n);
    add_ptr = (32'(s) >= MAX_WINDOW) ? IW'(s - (CW+1)'(MAX_WINDOW)) : IW'(s);
  endfunction

  logic signed [SAMPLE_WIDTH-1:0] ring_mem [MAX_WINDOW];
  logic signed [SAMPLE_WIDTH-1:0] lo_val [MAX_WINDOW];
  logic signed [SAMPLE_WIDTH-1:0] hi_val [MAX_WINDOW];
  logic [TW-1:0] lo_tag [MAX_WINDOW];
  logic [TW-1:0] hi_tag [MAX_WINDOW];

  logic [IW-1:0] oldest_q, lo_head_q, hi_head_q;
  logic [CW-1:0] fill_q, lo_size_q, hi_size_q;
  logic [TW-1:0] tag_q;
  logic signed [SW-1:0] sum_q;
  logic signed [SAMPLE_WIDTH-1:0] samp_q, old_q;
  logic drop_q, sub_q;

  // registered reads
  logic signed [SAMPLE_WIDTH-1:0] lo_tail_q, hi_tail_q, lo_hv_q, hi_hv_q;
  logic [TW-1:0] lo_ht_q, hi_ht_q;

  logic [IW-1:0] lo_tail_a, hi_tail_a;
  assign lo_tail_a = add_ptr(lo_head_q, lo_size_q - CW'(1));
  assign hi_tail_a = add_ptr(hi_head_q, hi_size_q - CW'(1));

  // a push into an empty queue lands at its head: forward the new sample
  always_ff @(posedge clk_i) begin
    old_q     <= ring_mem[oldest_q];
    lo_tail_q <= lo_val[lo_tail_a];
    hi_tail_q <= hi_val[hi_tail_a];
    lo_hv_q   <= (cmd_i.push && lo_size_q == '0) ? samp_q : lo_val[lo_head_q];
    hi_hv_q   <= (cmd_i.push && hi_size_q == '0) ? samp_q : hi_val[hi_head_q];
    lo_ht_q   <= lo_tag[lo_head_q];
    hi_ht_q   <= hi_tag[hi_head_q];
    if (cmd_i.push) begin
      ring_mem[add_ptr(oldest_q, fill_q)] <= samp_q;
      lo_val[add_ptr(lo_head_q, lo_size_q)] <= samp_q;
      lo_tag[add_ptr(lo_head_q, lo_size_q)] <= tag_q;
      hi_val[add_ptr(hi_head_q, hi_size_q)] <= samp_q;
      hi_tag[add_ptr(hi_head_q, hi_size_q)] <= tag_q;
    end
  end

  // pop decisions use the tail read of the previous cycle; a pop step
  // shows valid data only after a settle step
  logic lo_rd_ok_q, hi_rd_ok_q;
  logic lo_pop, hi_pop;
  assign lo_pop = lo_rd_ok_q && lo_size_q != '0 && lo_tail_q > samp_q;
  assign hi_pop = hi_rd_ok_q && hi_size_q != '0 && hi_tail_q < samp_q;
  assign sts_o.low_pop_more = !lo_rd_ok_q || lo_pop;
  assign sts_o.hi_pop_more  = !hi_rd_ok_q || hi_pop;

  logic [TW-1:0] period, tag_next;
  logic [TW:0] t1;
  assign period = {w, 1'b0};
  assign t1 = (TW+1)'(tag_q) + (TW+1)'(1);
  assign tag_next = (t1 >= (TW+1)'(period)) ? '0 : TW'(t1);

  function automatic logic expired(input logic [TW-1:0] cur, input logic [TW-1:0] t,
                                   input logic [TW-1:0] per, input logic [CW-1:0] wv);
    logic [TW:0] a;
    a = (TW+1)'(cur) + (TW+1)'(per) - (TW+1)'(t);
    if (a >= (TW+1)'(per)) a = a - (TW+1)'(per);
    expired = (a == (TW+1)'(wv));
  endfunction

  // divider
  localparam int unsigned DW = SW;
  logic [DW-1:0] rem_q, quo_q;
  logic [CW-1:0] den_q;
  logic neg_q;
  logic [$clog2(DW+1)-1:0] cnt_q;
  logic signed [SW-1:0] num;
  logic [CW-1:0] den;
  always_comb begin
    if (fill_q > CW'(2)) begin
      num = sum_q - SW'(lo_hv_q) - SW'(hi_hv_q);
      den = fill_q - CW'(2);
    end else begin
      num = sum_q;
      den = fill_q;
    end
  end
  logic [DW:0] trial;
  assign trial = {rem_q[DW-1:0], quo_q[DW-1]} - (DW+1)'(den_q);
  assign sts_o.div_done = (cnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_cfg_q <= WindowReset;
      oldest_q <= '0; fill_q <= '0; sum_q <= '0; tag_q <= '0;
      lo_head_q <= '0; lo_size_q <= '0; hi_head_q <= '0; hi_size_q <= '0;
      drop_q <= 1'b0; sub_q <= 1'b0; lo_rd_ok_q <= 1'b0; hi_rd_ok_q <= 1'b0;
      cnt_q <= '0;
    end else if (cmd_i.clear) begin
      win_cfg_q <= cfg_wdata_i;
      oldest_q <= '0; fill_q <= '0; sum_q <= '0; tag_q <= '0;
      lo_head_q <= '0; lo_size_q <= '0; hi_head_q <= '0; hi_size_q <= '0;
      drop_q <= 1'b0; sub_q <= 1'b0; lo_rd_ok_q <= 1'b0; hi_rd_ok_q <= 1'b0;
    end else begin
      sub_q <= 1'b0;
      if (cmd_i.take) begin
        tag_q  <= tag_next;
        drop_q <= (fill_q >= w);
        sub_q  <= (fill_q >= w);
      end
      if (sub_q) begin
        sum_q    <= sum_q - SW'(old_q);
        oldest_q <= inc_ptr(oldest_q);
        fill_q   <= fill_q - CW'(1);
      end
      if (cmd_i.expire) begin
        if (drop_q && lo_size_q != '0 && expired(tag_q, lo_ht_q, period, w)) begin
          lo_head_q <= inc_ptr(lo_head_q);
          lo_size_q <= lo_size_q - CW'(1);
        end
        if (drop_q && hi_size_q != '0 && expired(tag_q, hi_ht_q, period, w)) begin
          hi_head_q <= inc_ptr(hi_head_q);
          hi_size_q <= hi_size_q - CW'(1);
        end
        lo_rd_ok_q <= 1'b0;
        hi_rd_ok_q <= 1'b0;
      end
      if (cmd_i.low_pop) begin
        lo_rd_ok_q <= !lo_pop;
        if (lo_pop) lo_size_q <= lo_size_q - CW'(1);
      end
      if (cmd_i.hi_pop) begin
        hi_rd_ok_q <= !hi_pop;
        if (hi_pop) hi_size_q <= hi_size_q - CW'(1);
      end
      if (cmd_i.push) begin
        fill_q <= fill_q + CW'(1);
        sum_q  <= sum_q + SW'(samp_q);
        if (32'(lo_size_q) >= MAX_WINDOW) lo_head_q <= inc_ptr(lo_head_q);
        else lo_size_q <= lo_size_q + CW'(1);
        if (32'(hi_size_q) >= MAX_WINDOW) hi_head_q <= inc_ptr(hi_head_q);
        else hi_size_q <= hi_size_q + CW'(1);
        lo_rd_ok_q <= 1'b0;
        hi_rd_ok_q <= 1'b0;
      end
      if (cmd_i.div_start) begin
        cnt_q <= ($clog2(DW+1))'(DW);
      end else if (cmd_i.div_step && cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) samp_q <= sample_i;
    if (cmd_i.div_start) begin
      neg_q <= num[SW-1];
      quo_q <= num[SW-1] ? DW'(-num) : DW'(num);
      rem_q <= '0;
      den_q <= den;
    end else if (cmd_i.div_step && cnt_q != '0) begin
      if (!trial[DW]) begin
        rem_q <= trial[DW-1:0];
        quo_q <= {quo_q[DW-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[DW-2:0], quo_q[DW-1]};
        quo_q <= {quo_q[DW-2:0], 1'b0};
      end
    end
  end

  logic [DW-1:0] q_signed;
  assign q_signed = neg_q ? -quo_q : quo_q;
  assign filtered_o   = q_signed[SAMPLE_WIDTH-1:0];
  assign held_count_o = CfgWidth'(fill_q);

  `ASSERT_IMPL(a_fill_le_w, clk_i, rst_ni, cmd_i.div_start, fill_q <= w && fill_q != '0)
  `ASSERT_IMPL(a_lo_nonempty, clk_i, rst_ni, cmd_i.div_start, lo_size_q != '0)
  `ASSERT_IMPL(a_hi_nonempty, clk_i, rst_ni, cmd_i.div_start, hi_size_q != '0)
endmodule

/* rtl/sliding_trimmed_mean_filter.sv */
// Top level of the sliding trimmed mean filter.
// Joins stmf_ctrl and stmf_datapath; depends on stmf_pkg.
//
// channel  dir  tdata bits                      notes
// s_axis   in   [15:0] sample                   one transfer per sample
// m_axis   out  [15:0] filtered, [22:16] count  padded to 24 bits
// cfg      in   [6:0] win_len                   write clears the window
//
// Steps per item: expire, settle and compare per queue and per popped tail entry,
// push, divide setup, 24 divide steps and done, out.
// Reset: window 5, empty window. Output holds until taken; next sample
// is accepted in the same cycle the result is taken.
module sliding_trimmed_mean_filter
  import stmf_pkg::*;
#(
  parameter int unsigned MAX_WINDOW   = MaxWindow,
  parameter int unsigned SAMPLE_WIDTH = SampleWidth
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [SAMPLE_WIDTH-1:0] s_axis_tdata,   // [SAMPLE_WIDTH-1:0] sample
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [((SAMPLE_WIDTH+CfgWidth+7)/8)*8-1:0] m_axis_tdata, // filtered, held_count
  input  logic                    cfg_we_i,
  input  logic [CfgWidth-1:0]     cfg_wdata_i
);

  localparam int unsigned OW = ((SAMPLE_WIDTH + CfgWidth + 7) / 8) * 8;

  stmf_cmd_t cmd;
  stmf_sts_t sts;
  logic signed [SAMPLE_WIDTH-1:0] filtered;
  logic [CfgWidth-1:0] held_count;

  stmf_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .cfg_we_i, .sts_i(sts), .cmd_o(cmd)
  );

  stmf_datapath #(.MAX_WINDOW(MAX_WINDOW), .SAMPLE_WIDTH(SAMPLE_WIDTH)) u_dp (
    .clk_i, .rst_ni, .cfg_wdata_i,
    .sample_i(s_axis_tdata), .cmd_i(cmd), .sts_o(sts),
    .filtered_o(filtered), .held_count_o(held_count)
  );

  assign m_axis_tdata = OW'({held_count, filtered});
endmodule

/* verif/testbench.sv */
// Self-checking bench for sliding_trimmed_mean_filter over its stream ports.
// Needs the RTL and stmf_pkg; it keeps its own window model and checks every output transfer.
module testbench;
  import stmf_pkg::*;

  typedef struct {
    logic signed [15:0] filt;
    logic [6:0]         cnt;
  } mean_t;

  typedef struct {
    logic signed [15:0] smp;
    bit                 typed;
    logic signed [15:0] filt;
    logic [6:0]         cnt;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        cfg_we_i = 1'b0;
  logic [6:0]  cfg_wdata_i = '0;

  sliding_trimmed_mean_filter uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_wdata_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [6:0] win_reg = WindowReset;
  longint     window_vals[$];
  mean_t      pending_means[$];
  int         mismatches = 0;
  int         samples_sent = 0;
  int         means_seen = 0;
  int         idle_cycles = 0;
  bit         quiet = 1'b0;

  function automatic mean_t trimmed_mean_of(logic signed [15:0] smp);
    int     eff;
    longint sum, mn, mx, res;
    mean_t  m;
    eff = (win_reg == 0) ? 1 : win_reg;
    if (window_vals.size() >= eff) window_vals.delete(0);
    window_vals.insert(window_vals.size(), longint'(smp));
    sum = 0;
    mn = window_vals[0];
    mx = window_vals[0];
    foreach (window_vals[i]) begin
      sum += window_vals[i];
      if (window_vals[i] < mn) mn = window_vals[i];
      if (window_vals[i] > mx) mx = window_vals[i];
    end
    if (window_vals.size() > 2) res = (sum - mn - mx) / longint'(window_vals.size() - 2);
    else res = sum / longint'(window_vals.size());
    m.filt = res[15:0];
    m.cnt  = 7'(window_vals.size());
    return m;
  endfunction

  task automatic send_sample(logic signed [15:0] smp, bit typed = 0, mean_t typed_mean = '{0, 0});
    mean_t m;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    // tready is settled mid-cycle and holds until the next rising edge
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    m = trimmed_mean_of(smp);
    pending_means.insert(pending_means.size(), typed ? typed_mean : m);
    samples_sent++;
  endtask

  task automatic drain_and_set_window(logic [6:0] w);
    s_axis_tvalid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    win_reg = w;
    window_vals.delete();
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'(int'($urandom_range(0, 7)) - 4);
      3: return 16'(int'($urandom_range(0, 200)) - 100);
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic random_phase(int n);
    logic signed [15:0] last;
    last = 0;
    repeat (n) begin
      // repeats exercise ties in the min/max tracking
      if ($urandom_range(0, 4) == 0) send_sample(last);
      else begin
        last = rand_sample();
        send_sample(last);
      end
    end
  endtask

  // receiver stalls in bursts
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (quiet) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left    <= $urandom_range(1, 10) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    mean_t exp_m;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      means_seen++;
      if (pending_means.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output transfer: %h", m_axis_tdata);
      end else begin
        exp_m = pending_means[0];
        pending_means.delete(0);
        if (m_axis_tdata[15:0] !== exp_m.filt || m_axis_tdata[22:16] !== exp_m.cnt) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: filtered exp %0d got %0d, count exp %0d got %0d",
                     exp_m.filt, $signed(m_axis_tdata[15:0]), exp_m.cnt, m_axis_tdata[22:16]);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 3000) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  row_t dir_rows[$];

  initial begin
    dir_rows = '{
      '{16'sh7fff, 1, 16'sh7fff, 7'd1},
      '{16'sh8000, 1, 16'sh0000, 7'd2},
      '{16'sh0000, 1, 16'sh0000, 7'd3},
      '{16'sh0000, 0, 0, 0},
      '{16'sh0000, 0, 0, 0},
      '{16'sh0000, 0, 0, 0},
      '{-16'sd1,   0, 0, 0},
      '{16'sh7fff, 0, 0, 0},
      '{16'sh7fff, 0, 0, 0},
      '{16'sh7fff, 0, 0, 0},
      '{16'sh7fff, 0, 0, 0},
      '{16'sh7fff, 0, 0, 0},
      '{16'sh8000, 0, 0, 0},
      '{16'sh8000, 0, 0, 0},
      '{16'sh8000, 0, 0, 0},
      '{16'sh8000, 0, 0, 0},
      '{16'sh8000, 0, 0, 0},
      '{16'sh5555, 0, 0, 0},
      '{16'shaaaa, 0, 0, 0},
      '{-16'sd7,   0, 0, 0},
      '{16'sd7,    0, 0, 0},
      '{16'sd3,    0, 0, 0}
    };
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      send_sample(dir_rows[i].smp, dir_rows[i].typed, '{dir_rows[i].filt, dir_rows[i].cnt});

    drain_and_set_window(7'd1);   random_phase(50);
    drain_and_set_window(7'd0);   random_phase(30);
    drain_and_set_window(7'd127); random_phase(190);
    drain_and_set_window(7'd2);   random_phase(50);
    drain_and_set_window(7'd3);   random_phase(50);
    drain_and_set_window(7'($urandom_range(4, 126))); random_phase(100);
    drain_and_set_window(7'($urandom_range(4, 20)));
    quiet = 1'b1;
    random_phase(160);

    s_axis_tvalid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("%0d samples sent, %0d means checked, windows 0,1,2,3,5,127 and random",
             samples_sent, means_seen);
    if (mismatches == 0 && pending_means.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d means never seen", mismatches, pending_means.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* sliding_trimmed_mean_filter.f */
+incdir+rtl
rtl/stmf_pkg.sv
rtl/stmf_ctrl.sv
rtl/stmf_datapath.sv
rtl/sliding_trimmed_mean_filter.sv
verif/testbench.sv
